>>> src/gbe_pkg.sv
// Shared types and constants for the glyph bitmap expander.
// No dependencies; every module of the block imports this package.
package gbe_pkg;

  localparam int BYTE_BITS = 8;
  localparam int COORD_W   = 16;
  localparam int COLOR_W   = 16;
  localparam int COL_W     = 6;
  localparam int IDX_W     = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FG_COLOR    = 2'd0;
  localparam logic [1:0] CFG_BG_COLOR    = 2'd1;
  localparam logic [1:0] CFG_GLYPH_WIDTH = 2'd2;
  localparam logic [1:0] CFG_TRANSPARENT = 2'd3;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [COL_W-1:0]   glyph_width;
    logic               transparent_mode;
  } cfg_t;

  // Pixels produced by one font byte: x of bit 0, row, emit mask, raw bits
  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [BYTE_BITS-1:0] mask;
    logic [BYTE_BITS-1:0] bits;
  } burst_t;

endpackage

>>> src/gbe_expand.sv
// Per-byte expansion: glyph position state and the pixel burst of one byte.
// Depends on gbe_pkg.
module gbe_expand #(
  parameter int MAX_GLYPH_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gbe_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  logic [7:0]           font_bits,
  input  logic                 glyph_start,
  input  logic [15:0]          origin_x,
  input  logic [15:0]          origin_y,
  output gbe_pkg::burst_t      burst
);
  import gbe_pkg::*;

  logic [COL_W-1:0]   column_count;
  logic [COORD_W-1:0] row_offset;
  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;

  logic [COL_W-1:0]   column_count_next;
  logic [COORD_W-1:0] row_offset_next;

  logic [COL_W-1:0]   width;
  logic [COL_W-1:0]   col0;
  logic [COORD_W-1:0] row0;
  logic [COORD_W-1:0] bx;
  logic [COORD_W-1:0] by;
  logic [COL_W:0]     remain;
  logic [3:0]         n_take;
  logic               row_end;
  logic [BYTE_BITS-1:0] take_mask;

  always_comb begin
    width = cfg.glyph_width;
    if (width == '0) begin
      width = COL_W'(1);
    end
    if ({1'b0, width} > (COL_W+1)'(MAX_GLYPH_WIDTH)) begin
      width = COL_W'(MAX_GLYPH_WIDTH);
    end

    // start flag restarts the glyph at its origin
    col0 = glyph_start ? '0 : column_count;
    row0 = glyph_start ? '0 : row_offset;
    bx   = glyph_start ? origin_x : base_x;
    by   = glyph_start ? origin_y : base_y;

    remain = {1'b0, width} - {1'b0, col0};
    if ({1'b0, col0} + (COL_W+1)'(1) >= {1'b0, width}) begin
      n_take  = 4'd1;
      row_end = 1'b1;
    end else if (remain <= (COL_W+1)'(BYTE_BITS)) begin
      n_take  = remain[3:0];
      row_end = 1'b1;
    end else begin
      n_take  = 4'(BYTE_BITS);
      row_end = 1'b0;
    end

    take_mask = 8'hFF >> (4'(BYTE_BITS) - n_take);

    if (row_end) begin
      column_count_next = '0;
      row_offset_next   = row0 + COORD_W'(1);
    end else begin
      column_count_next = col0 + COL_W'(BYTE_BITS);
      row_offset_next   = row0;
    end

    burst.x    = bx + COORD_W'(col0);
    burst.y    = by + row0;
    burst.mask = take_mask & (cfg.transparent_mode ? font_bits : 8'hFF);
    burst.bits = font_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_offset   <= '0;
      base_x       <= '0;
      base_y       <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_offset   <= row_offset_next;
      base_x       <= bx;
      base_y       <= by;
    end
  end

endmodule

>>> src/gbe_serial.sv
// Result register for one byte's pixels; drains one pixel per cycle while pix_ready is high.
// Depends on gbe_pkg.
module gbe_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  gbe_pkg::cfg_t        cfg,
  input  logic                 load,
  input  gbe_pkg::burst_t      burst_in,
  output logic                 load_ready,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output logic [15:0]          pixel_x,
  output logic [15:0]          pixel_y,
  output logic [15:0]          pixel_color,
  output logic                 run_last
);
  import gbe_pkg::*;

  logic [COORD_W-1:0]   burst_x;
  logic [COORD_W-1:0]   burst_y;
  logic [BYTE_BITS-1:0] burst_bits;
  logic [BYTE_BITS-1:0] mask;
  logic [BYTE_BITS-1:0] sel;
  logic [IDX_W-1:0]     idx;
  logic                 found;

  // pick the lowest pending pixel
  always_comb begin
    sel   = '0;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      if (mask[i] && !found) begin
        sel[i] = 1'b1;
        idx    = IDX_W'(i);
        found  = 1'b1;
      end
    end
  end

  assign pix_valid   = |mask;
  assign run_last    = (mask & ~sel) == '0;
  assign pixel_x     = burst_x + COORD_W'(idx);
  assign pixel_y     = burst_y;
  assign pixel_color = burst_bits[idx] ? cfg.fg_color : cfg.bg_color;
  assign load_ready  = !pix_valid || (pix_ready && run_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= burst_in.mask;
    end else if (pix_valid && pix_ready) begin
      mask <= mask & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_x    <= burst_in.x;
      burst_y    <= burst_in.y;
      burst_bits <= burst_in.bits;
    end
  end

endmodule

>>> src/glyph_bitmap_expander.sv
// Top level of the glyph bitmap expander: configuration registers and stream ports.
// Depends on gbe_pkg, gbe_expand and gbe_serial.
//
// Takes font bitmap bytes (bit 0 leftmost) on the slave stream and emits
// pixels on the master stream, one pixel per cycle while m_tready is high.
// A byte is expanded in the cycle it is transferred and its pixels (zero to
// eight) go into a result register; the next byte is taken in the same cycle
// as the last pixel of the current one leaves, so a byte is never taken while
// pixels are pending. A byte that yields none (a transparent byte with no set
// bits) leaves the register empty and ready for the next byte. The pixel port
// sets the byte rate. tuser flags the first byte of a glyph and loads its
// origin; tlast marks the last pixel of each byte. Rows span ceil(width/8)
// bytes; bits past the row width are dropped. Coordinates wrap modulo 65536.
// Write configuration only while the block is idle.
module glyph_bitmap_expander #(
  parameter int MAX_GLYPH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // font_bits[7:0], origin_x[23:8], origin_y[39:24]
  input  logic        s_tuser,   // glyph_start
  // pixel output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pixel_x[15:0], pixel_y[31:16], pixel_color[47:32]
  output logic        m_tlast    // run_last
);
  import gbe_pkg::*;

  cfg_t   cfg;
  burst_t burst;
  logic   s_xfer;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [15:0] pixel_color;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color         <= 16'hFFFF;
      cfg.bg_color         <= '0;
      cfg.glyph_width      <= COL_W'(8);
      cfg.transparent_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FG_COLOR:    cfg.fg_color         <= cfg_data;
        CFG_BG_COLOR:    cfg.bg_color         <= cfg_data;
        CFG_GLYPH_WIDTH: cfg.glyph_width      <= cfg_data[COL_W-1:0];
        CFG_TRANSPARENT: cfg.transparent_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_xfer = s_tvalid && s_tready;

  // expand the byte and advance the glyph position on each input transfer
  gbe_expand #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_expand (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (s_xfer),
    .font_bits   (s_tdata[7:0]),
    .glyph_start (s_tuser),
    .origin_x    (s_tdata[23:8]),
    .origin_y    (s_tdata[39:24]),
    .burst       (burst)
  );

  // hold the burst and drain it one pixel per transfer
  gbe_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .load        (s_xfer),
    .burst_in    (burst),
    .load_ready  (s_tready),
    .pix_valid   (m_tvalid),
    .pix_ready   (m_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .run_last    (m_tlast)
  );

  assign m_tdata = {pixel_color, pixel_y, pixel_x};

  // a new byte never overwrites pixels still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s_xfer |-> (!m_tvalid || (m_tready && m_tlast)))
    else $error("byte accepted while pixels pending");

  // a pixel that is not the last of its byte is followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("pixel run ended without tlast");

  // pixels of one byte share a row
  a_same_row: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tdata[31:16] == $past(m_tdata[31:16])))
    else $error("row changed inside a byte");

endmodule

>>> test/tb_glyph_bitmap_expander.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_bitmap_expander: font bytes in, pixels out.
// Depends on gbe_pkg and the block's RTL; predicts every pixel internally.
module tb_glyph_bitmap_expander;
  import gbe_pkg::*;

  localparam int GLYPH_MAX   = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // font_bits[7:0], origin_x[23:8], origin_y[39:24]
  logic        s_tuser;   // glyph_start
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // pixel_x[15:0], pixel_y[31:16], pixel_color[47:32]
  logic        m_tlast;   // run_last

  glyph_bitmap_expander #(
    .MAX_GLYPH_WIDTH(GLYPH_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Predictor copy of the configuration registers
  logic [15:0] reg_fg;
  logic [15:0] reg_bg;
  logic [5:0]  reg_width;
  logic        reg_transparent;

  // Predictor copy of the glyph position
  logic [5:0]  pos_col;
  logic [15:0] pos_row;
  logic [15:0] pos_base_x;
  logic [15:0] pos_base_y;

  pixel_t expected_pixels[$];

  int  errors;
  int  bytes_sent;
  int  pixels_checked;
  int  config_phases;
  int  cycles;
  bit  src_gaps;
  bit  sink_gaps;
  logic sink_hold;

  always #4 clk = ~clk;

  // Watchdog: end the run if it stalls somewhere.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL glyph_bitmap_expander");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40)
      $display("mismatch at pixel %0d: %s got 0x%0h want 0x%0h", pixels_checked, what, got,
               want);
    errors++;
  endtask

  function automatic int active_width();
    int w;
    w = int'(reg_width);
    if (w == 0) w = 1;
    if (w > GLYPH_MAX) w = GLYPH_MAX;
    return w;
  endfunction

  // Expand one accepted font byte into the pixels it must produce.
  task automatic expand_byte(input logic [7:0] bits, input logic start,
                             input logic [15:0] ox, input logic [15:0] oy);
    int     w;
    int     n_before;
    bit     row_done;
    pixel_t px;
    w = active_width();
    if (start) begin
      pos_base_x = ox;
      pos_base_y = oy;
      pos_col    = '0;
      pos_row    = '0;
    end
    n_before = expected_pixels.size();
    row_done = 1'b0;
    for (int t = 0; t < BYTE_BITS && !row_done; t++) begin
      if (bits[t] || !reg_transparent) begin
        px.x     = pos_base_x + {10'd0, pos_col};
        px.y     = pos_base_y + pos_row;
        px.color = bits[t] ? reg_fg : reg_bg;
        px.last  = 1'b0;
        expected_pixels.push_back(px);
      end
      // A column at or past the row width closes the row, even after a width cut.
      if (int'(pos_col) + 1 >= w) begin
        pos_col  = '0;
        pos_row  = pos_row + 16'd1;
        row_done = 1'b1;
      end else begin
        pos_col = pos_col + 6'd1;
      end
    end
    if (expected_pixels.size() > n_before) begin
      px = expected_pixels.pop_back();
      px.last = 1'b1;
      expected_pixels.push_back(px);
    end
  endtask

  // Offer one byte, with optional idle cycles first, and hold it until transferred.
  task automatic send_byte(input logic [7:0] bits, input logic start,
                           input logic [15:0] ox, input logic [15:0] oy);
    if (src_gaps) begin
      while ($urandom_range(99) < 24) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {oy, ox, bits};
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expand_byte(bits, start, ox, oy);
    bytes_sent++;
  endtask

  // Drop valid, wait for every expected pixel, then let a zero-pixel byte finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_FG_COLOR:    reg_fg          = val;
      CFG_BG_COLOR:    reg_bg          = val;
      CFG_GLYPH_WIDTH: reg_width       = val[5:0];
      CFG_TRANSPARENT: reg_transparent = val[0];
      default: ;
    endcase
  endtask

  // Write all four registers while idle; upper bits of the narrow ones carry junk.
  task automatic set_config(input logic [15:0] fg, input logic [15:0] bg,
                            input logic [5:0] width, input logic transparent);
    drain();
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
    write_reg(CFG_GLYPH_WIDTH, {10'($urandom), width});
    write_reg(CFG_TRANSPARENT, {15'($urandom), transparent});
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  // Pixel sink: random backpressure, a forced hold-off, and the scoreboard check.
  always @(posedge clk) begin
    if (rst || sink_hold)
      m_tready <= 1'b0;
    else if (sink_gaps)
      m_tready <= ($urandom_range(99) >= 24);
    else
      m_tready <= 1'b1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel x", int'(m_tdata[15:0]), 0);
      end else begin
        pixel_t want;
        want = expected_pixels.pop_front();
        if (m_tdata[15:0] !== want.x)
          report_mismatch("pixel_x", int'(m_tdata[15:0]), int'(want.x));
        if (m_tdata[31:16] !== want.y)
          report_mismatch("pixel_y", int'(m_tdata[31:16]), int'(want.y));
        if (m_tdata[47:32] !== want.color)
          report_mismatch("pixel_color", int'(m_tdata[47:32]), int'(want.color));
        if (m_tlast !== want.last)
          report_mismatch("run_last", int'(m_tlast), int'(want.last));
      end
      pixels_checked++;
    end
  end

  // No start flag yet: the glyph sits at 0,0 with the reset configuration.
  task automatic test_reset_state();
    send_byte(8'hFF, 1'b0, 16'h1111, 16'h2222);
    send_byte(8'h00, 1'b0, 16'h3333, 16'h4444);
  endtask

  // Origins at both ends, coordinates wrapping past 0xFFFF, inverted color extremes.
  task automatic test_origin_extremes();
    set_config(16'h0000, 16'hFFFF, 6'd8, 1'b0);
    send_byte(8'h5A, 1'b1, 16'hFFFF, 16'hFFFF);
    send_byte(8'h81, 1'b0, 16'h0000, 16'h0000);
    send_byte(8'hFF, 1'b1, 16'h0000, 16'h0000);
  endtask

  // Row spanning several bytes with dropped tail bits, width zero and an oversize width.
  task automatic test_width_limits();
    set_config(16'hF800, 16'h07E0, 6'd13, 1'b0);
    send_byte(8'hFF, 1'b1, 16'h0010, 16'h0020);
    send_byte(8'hFF, 1'b0, 16'h0000, 16'h0000);
    send_byte(8'hC3, 1'b0, 16'h0000, 16'h0000);
    send_byte(8'h0F, 1'b0, 16'h0000, 16'h0000);
    set_config(16'h001F, 16'hAAAA, 6'd0, 1'b0);
    send_byte(8'hAA, 1'b1, 16'h0100, 16'h0200);
    send_byte(8'h55, 1'b0, 16'h0000, 16'h0000);
    send_byte(8'h01, 1'b0, 16'h0000, 16'h0000);
    set_config(16'h1234, 16'h4321, 6'd63, 1'b0);
    send_byte(8'h01, 1'b1, 16'hFFF0, 16'h0005);
    for (int i = 0; i < 4; i++)
      send_byte(8'($urandom), 1'b0, 16'h0000, 16'h0000);
  endtask

  // Lower the width after the column has passed it: one pixel, then the row ends.
  task automatic test_width_cut_mid_row();
    set_config(16'hFFFF, 16'h0000, 6'd20, 1'b0);
    send_byte(8'hF0, 1'b1, 16'h0040, 16'h0080);
    send_byte(8'h0F, 1'b0, 16'h0000, 16'h0000);
    set_config(16'hFFFF, 16'h0000, 6'd4, 1'b0);
    send_byte(8'hFE, 1'b0, 16'h0000, 16'h0000);
    send_byte(8'hFF, 1'b0, 16'h0000, 16'h0000);
  endtask

  // Transparent mode: empty bytes emit nothing but still advance the row.
  task automatic test_transparent();
    set_config(16'hBEEF, 16'h1357, 6'd8, 1'b1);
    send_byte(8'h00, 1'b1, 16'h0500, 16'h0600);
    send_byte(8'h81, 1'b0, 16'h0000, 16'h0000);
    send_byte(8'h00, 1'b0, 16'h0000, 16'h0000);
    send_byte(8'hFF, 1'b0, 16'h0000, 16'h0000);
  endtask

  // Hold the pixel port off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    set_config(16'($urandom), 16'($urandom), 6'd8, 1'b0);
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++)
          send_byte(8'($urandom), (i == 0), 16'($urandom), 16'($urandom));
      end
    join
  endtask

  // One-pixel rows starting just below 0xFFFF, so the row coordinate wraps to zero.
  task automatic test_row_wrap();
    src_gaps = 1'b0;
    set_config(16'hFFFF, 16'h0000, 6'd1, 1'b1);
    send_byte(8'h01, 1'b1, 16'h1234, 16'hFFFE);
    for (int i = 0; i < 3; i++)
      send_byte(8'h01, 1'b0, 16'($urandom), 16'($urandom));
    src_gaps = 1'b1;
  endtask

  // Random phases: mostly well-formed glyphs with random content, some noise bytes.
  task automatic test_random_glyphs();
    logic [5:0] width_pick[10] = '{6'd1, 6'd3, 6'd8, 6'd13, 6'd16, 6'd32, 6'd0, 6'd63,
                                   6'd5, 6'd33};
    int         n_bytes;
    int         per_row;
    int         rows;
    logic [15:0] ox;
    logic [15:0] oy;
    for (int phase = 0; phase < 4; phase++) begin
      set_config(16'($urandom), 16'($urandom), width_pick[$urandom_range(9)], phase[0]);
      // One phase runs with no idling on either side.
      src_gaps  = (phase != 2);
      sink_gaps = (phase != 2);
      n_bytes = 0;
      while (n_bytes < 14) begin
        if ($urandom_range(99) < 80) begin
          per_row = (active_width() + 7) / 8;
          rows    = $urandom_range(1, 3);
          ox = ($urandom_range(3) == 0) ? 16'hFFF8 + 16'($urandom_range(7)) : 16'($urandom);
          oy = ($urandom_range(3) == 0) ? 16'hFFFE + 16'($urandom_range(1)) : 16'($urandom);
          send_byte(8'($urandom), 1'b1, ox, oy);
          for (int k = 1; k < rows * per_row; k++)
            send_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
          n_bytes += rows * per_row;
        end else begin
          send_byte(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
          n_bytes++;
        end
      end
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    clk       = 1'b0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FG_COLOR;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    sink_hold <= 1'b0;
    m_tready  <= 1'b0;
    src_gaps       = 1'b1;
    sink_gaps      = 1'b1;
    errors         = 0;
    bytes_sent     = 0;
    pixels_checked = 0;
    config_phases  = 0;
    reg_fg          = 16'hFFFF;
    reg_bg          = 16'h0000;
    reg_width       = 6'd8;
    reg_transparent = 1'b0;
    pos_col    = '0;
    pos_row    = '0;
    pos_base_x = '0;
    pos_base_y = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_origin_extremes();
    test_width_limits();
    test_width_cut_mid_row();
    test_transparent();
    test_backpressure();
    test_random_glyphs();
    test_row_wrap();

    drain();
    repeat (8) @(posedge clk);

    $display("run covered %0d font bytes, %0d pixels checked, %0d register settings",
             bytes_sent, pixels_checked, config_phases);
    $display("widths 0 to 63, both modes, origin and row wrap, and a long sink stall");
    if (errors == 0) begin
      $display("PASS glyph_bitmap_expander");
    end else begin
      $display("FAIL glyph_bitmap_expander");
    end
    $finish;
  end

endmodule
